FILE: design/rbfd_pkg.sv
package rbfd_pkg;

    localparam int RING_DEPTH  = 256;
    localparam int MAX_FRAME   = 64;
    localparam int CHECK_BYTES = 2;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int LEN_W       = $clog2(MAX_FRAME + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] REG_HEADER  = 2'd0;
    localparam logic [1:0] REG_LEN_OFS = 2'd1;
    localparam logic [1:0] REG_CMD_OFS = 2'd2;

    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_PARSE   = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [7:0]               frame_byte;
        logic [7:0]               frame_command;
        logic [LEN_W-1:0]         frame_length;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_item;

    // one CRC byte step, eight bit steps (narrow dependent chain)
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

FILE: design/rbfd_if.sv
interface rbfd_in_if;
    logic              valid;
    logic              ready;
    rbfd_pkg::t_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbfd_out_if;
    logic              valid;
    logic              ready;
    rbfd_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/rbfd_ram.sv
module rbfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/ring_buffer_frame_deframer_crc16.sv
// Ring-buffer frame deframer with Modbus CRC-16. A receive beat (command 0)
// writes rx_byte into a 256-entry ring RAM and emits nothing; the write
// pointer wraps with no overflow check, so 256 unread bytes read as an
// empty ring. A parse beat (command 1) runs a sequencer over the single RAM
// read port. The header search streams one byte per cycle through a 32-bit
// window, overlapping each registered read with the next address. The two
// length bytes, the two check bytes, the command byte and each of the len-2
// CRC bytes are each read as an address step, then a registered data step.
// The CRC bytes go through one shared byte-wide CRC unit. A final pass emits
// each frame byte as one output beat; the next frame byte is read only once
// the previous beat has been taken. A failed parse gives one beat with kind 0
// and last 1. The input is not ready while a parse is in progress or an
// output beat is pending. Configuration writes (index 0 header, 1 length
// offset, 2 command offset) take effect at once and must only occur while
// idle.
module ring_buffer_frame_deframer_crc16 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    rbfd_in_if.sink              i_in,
    rbfd_out_if.source           o_out
);
    localparam int PW = rbfd_pkg::PTR_W;
    localparam int LW = rbfd_pkg::LEN_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SRCH  = 10'b0000000010,  // issue/consume header window bytes
        S_LEN   = 10'b0000000100,  // read two length bytes
        S_CHK   = 10'b0000001000,  // read check bytes and command byte
        S_CRC   = 10'b0000010000,  // crc over len-2 bytes
        S_EMIT  = 10'b0000100000,  // read frame byte
        S_WAIT  = 10'b0001000000,  // unused, returns to idle
        S_NONE  = 10'b0010000000,
        S_SPARE = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state           r_state;
    logic [31:0]      r_header;
    logic [3:0]       r_len_ofs, r_cmd_ofs;
    logic [PW-1:0]    r_rd_ptr, r_wr_ptr;
    logic [PW-1:0]    r_base;      // candidate header start
    logic [PW:0]      r_avail;     // unread bytes from r_base
    logic [PW:0]      r_cnt;       // bytes issued in this phase
    logic             r_pend;      // read issued, data next cycle
    logic [31:0]      r_win;
    logic [15:0]      r_len;
    logic [15:0]      r_crc, r_stored;
    logic [7:0]       r_cmd;
    logic [1:0]       r_sub;
    rbfd_pkg::t_result r_res;
    logic             r_ovalid;

    logic [PW-1:0]    s_raddr;
    logic [7:0]       s_rdata;
    logic             s_we;
    logic [PW:0]      s_unread;

    assign s_unread = {1'b0, r_wr_ptr - r_rd_ptr};
    assign s_we = i_in.valid && i_in.ready && (i_in.data.command == rbfd_pkg::CMD_RECEIVE);
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_res;

    rbfd_ram #(.WIDTH(8), .DEPTH(rbfd_pkg::RING_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(r_wr_ptr),
        .i_wdata(i_in.data.rx_byte),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    // read address: phase-specific offset from r_base
    always_comb begin
        s_raddr = r_base;
        case (r_state)
            S_SRCH: s_raddr = r_base + r_cnt[PW-1:0];
            S_LEN:  s_raddr = r_base + PW'(r_len_ofs) + PW'(r_sub[0]);
            S_CHK: begin
                case (r_sub)
                    2'd0:    s_raddr = r_base + PW'(r_len - 16'd2);
                    2'd1:    s_raddr = r_base + PW'(r_len - 16'd1);
                    default: s_raddr = r_base + PW'(r_cmd_ofs);
                endcase
            end
            S_CRC, S_EMIT: s_raddr = r_base + r_cnt[PW-1:0];
            default: s_raddr = r_base;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_header  <= '0;
            r_len_ofs <= 4'd5;
            r_cmd_ofs <= 4'd9;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_ovalid  <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rbfd_pkg::REG_HEADER:  r_header  <= i_cfg_data;
                    rbfd_pkg::REG_LEN_OFS: r_len_ofs <= i_cfg_data[3:0];
                    rbfd_pkg::REG_CMD_OFS: r_cmd_ofs <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (s_we) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready &&
                        i_in.data.command == rbfd_pkg::CMD_PARSE) begin
                        r_base  <= r_rd_ptr;
                        r_avail <= s_unread;
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                        r_win   <= '0;
                        if (s_unread < (PW+1)'(4)) begin
                            r_state <= S_NONE;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    // issue byte r_cnt, consume byte r_cnt-1
                    if (r_pend) begin
                        if ({s_rdata, r_win[31:8]} == r_header && r_cnt >= (PW+1)'(4)) begin
                            // header starts at r_cnt-4
                            r_base  <= r_base + r_cnt[PW-1:0] - PW'(4);
                            r_avail <= r_avail - r_cnt + (PW+1)'(4);
                            r_rd_ptr <= r_base + r_cnt[PW-1:0] - PW'(4);
                            r_pend  <= 1'b0;
                            r_sub   <= '0;
                            r_state <= S_LEN;
                        end else if (r_cnt == r_avail) begin
                            r_rd_ptr <= r_base + r_avail[PW-1:0] - PW'(3);
                            r_pend   <= 1'b0;
                            r_state  <= S_NONE;
                        end else begin
                            r_win  <= {s_rdata, r_win[31:8]};
                            r_cnt  <= r_cnt + 1'b1;
                        end
                    end else begin
                        r_pend <= 1'b1;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                S_LEN: begin
                    if (r_avail < (PW+1)'(6) ||
                        r_avail < (PW+1)'(r_len_ofs) + (PW+1)'(2)) begin
                        r_rd_ptr <= r_base + 1'b1;
                        r_state  <= S_NONE;
                    end else if (!r_pend) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (r_sub[0]) begin
                            r_len[15:8] <= s_rdata;
                            r_sub   <= '0;
                            r_state <= S_SPARE;
                        end else begin
                            r_len[7:0] <= s_rdata;
                            r_sub <= 2'd1;
                        end
                    end
                end
                S_SPARE: begin
                    if (r_len > 16'(rbfd_pkg::MAX_FRAME) ||
                        r_len < 16'(r_cmd_ofs) + 16'(1 + rbfd_pkg::CHECK_BYTES) ||
                        r_len > 16'(r_avail)) begin
                        r_rd_ptr <= r_base + 1'b1;
                        r_state  <= S_NONE;
                    end else begin
                        r_sub   <= '0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!r_pend) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        case (r_sub)
                            2'd0: r_stored[7:0]  <= s_rdata;
                            2'd1: r_stored[15:8] <= s_rdata;
                            default: r_cmd <= s_rdata;
                        endcase
                        if (r_sub[1]) begin
                            r_cnt   <= '0;
                            r_crc   <= rbfd_pkg::CRC_INIT;
                            r_state <= S_CRC;
                        end else begin
                            r_sub <= r_sub + 1'b1;
                        end
                    end
                end
                S_CRC: begin
                    if (!r_pend) begin
                        if ((PW+1)'(r_cnt) == (PW+1)'(r_len - 16'd2)) begin
                            if (r_crc == r_stored) begin
                                r_cnt   <= '0;
                                r_state <= S_EMIT;
                            end else begin
                                r_rd_ptr <= r_base + 1'b1;
                                r_state  <= S_NONE;
                            end
                        end else begin
                            r_pend <= 1'b1;
                        end
                    end else begin
                        r_pend <= 1'b0;
                        r_crc  <= rbfd_pkg::crc_byte(r_crc, s_rdata);
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!r_pend) begin
                        if (!r_ovalid) r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        r_res.kind          <= 1'b1;
                        r_res.frame_byte    <= s_rdata;
                        r_res.frame_command <= r_cmd;
                        r_res.frame_length  <= LW'(r_len);
                        r_res.last          <= ((PW+1)'(r_len) == r_cnt + 1'b1);
                        r_ovalid <= 1'b1;
                        r_cnt    <= r_cnt + 1'b1;
                        if ((PW+1)'(r_len) == r_cnt + 1'b1) begin
                            r_rd_ptr <= r_base + PW'(r_len);
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_NONE: begin
                    r_res    <= '{kind: 1'b0, frame_byte: 8'd0, frame_command: 8'd0,
                                  frame_length: '0, last: 1'b1};
                    r_ovalid <= 1'b1;
                    r_state  <= S_DONE;
                end
                S_WAIT, S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/tb_ring_buffer_frame_deframer_crc16.sv
`timescale 1ns / 100ps

module tb_ring_buffer_frame_deframer_crc16;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = rbfd_pkg::REG_HEADER;
    logic [31:0] i_cfg_data = '0;

    rbfd_in_if  in_if ();
    rbfd_out_if out_if ();

    ring_buffer_frame_deframer_crc16 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the deframer: ring, pointers and registers.
    // ------------------------------------------------------------------
    logic [7:0]  shadow_ring [0:rbfd_pkg::RING_DEPTH-1];
    logic [7:0]  shadow_rd;
    logic [7:0]  shadow_wr;
    logic [31:0] hdr_word;
    int          len_ofs;
    int          cmd_ofs;

    rbfd_pkg::t_result frame_beats_q [$];   // expected output beats, oldest first
    int          errors = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;         // no-gap stretch on both sides

    function automatic logic [7:0] ring_byte(input int ofs);
        return shadow_ring[8'(int'(shadow_rd) + ofs)];
    endfunction

    function automatic int unread_bytes();
        return int'(8'(shadow_wr - shadow_rd));
    endfunction

    function automatic logic [15:0] crc16_modbus(input logic [7:0] buf_b [0:63],
                                                 input int count);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < count; i++) begin
            c ^= {8'h00, buf_b[i]};
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            end
        end
        return c;
    endfunction

    task automatic push_no_frame();
        rbfd_pkg::t_result r;
        r = '0;
        r.last = 1'b1;
        frame_beats_q.push_back(r);
    endtask

    // Advance the shadow by one accepted beat and queue what it should emit.
    task automatic predict_beat(input logic cmd, input logic [7:0] rx);
        int          avail;
        int          hit;
        int          flen;
        logic [31:0] w;
        logic [15:0] stored;
        logic [7:0]  fbuf [0:63];
        rbfd_pkg::t_result r;
        if (cmd == rbfd_pkg::CMD_RECEIVE) begin
            shadow_ring[shadow_wr] = rx;
            shadow_wr++;
            return;
        end
        avail = unread_bytes();
        if (avail < 4) begin
            push_no_frame();
            return;
        end
        hit = -1;
        for (int i = 0; i + 3 < avail && hit < 0; i++) begin
            w = {ring_byte(i + 3), ring_byte(i + 2), ring_byte(i + 1), ring_byte(i)};
            if (w == hdr_word) hit = i;
        end
        if (hit < 0) begin
            // keep the last three bytes, a header may straddle them
            shadow_rd = 8'(int'(shadow_rd) + avail - 3);
            push_no_frame();
            return;
        end
        shadow_rd = 8'(int'(shadow_rd) + hit);
        avail = unread_bytes();
        if (avail < 6 || avail < len_ofs + 2) begin
            shadow_rd++;
            push_no_frame();
            return;
        end
        flen = int'({ring_byte(len_ofs + 1), ring_byte(len_ofs)});
        if (flen > rbfd_pkg::MAX_FRAME || flen < cmd_ofs + 1 + rbfd_pkg::CHECK_BYTES ||
            flen > avail) begin
            shadow_rd++;
            push_no_frame();
            return;
        end
        for (int i = 0; i < 64; i++) fbuf[i] = (i < flen) ? ring_byte(i) : 8'h00;
        stored = {fbuf[flen-1], fbuf[flen-2]};
        if (crc16_modbus(fbuf, flen - rbfd_pkg::CHECK_BYTES) != stored) begin
            shadow_rd++;
            push_no_frame();
            return;
        end
        for (int i = 0; i < flen; i++) begin
            r.kind          = 1'b1;
            r.frame_byte    = fbuf[i];
            r.frame_command = fbuf[cmd_ofs];
            r.frame_length  = rbfd_pkg::LEN_W'(flen);
            r.last          = (i == flen - 1);
            frame_beats_q.push_back(r);
        end
        shadow_rd = 8'(int'(shadow_rd) + flen);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got 0x%0h want 0x%0h (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    // Mostly short gaps, a few long ones, none at all in a calm stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (calm || r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Input side: drive at the falling edge, handshake seen at the rising.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic cmd, input logic [7:0] rx);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        = 1'b1;
        in_if.data.command = cmd;
        in_if.data.rx_byte = rx;
        do @(posedge i_clk); while (!in_if.ready);
        predict_beat(cmd, rx);
        items_sent++;
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    // Register writes only once every queued beat has left and the block
    // has had time to settle after trailing receive beats.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        while (frame_beats_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            rbfd_pkg::REG_HEADER:  hdr_word = val;
            rbfd_pkg::REG_LEN_OFS: len_ofs  = int'(val[3:0]);
            rbfd_pkg::REG_CMD_OFS: cmd_ofs  = int'(val[3:0]);
            default: ;
        endcase
    endtask

    // Build one frame for the current registers and send it byte by byte.
    // flavor: 0 good, 1 one bit flipped, 2 cut short before the parse.
    task automatic send_frame(input int flavor, input bit longest);
        logic [7:0]  fbuf [0:63];
        logic [15:0] crc;
        int          flen;
        int          lo_min;
        int          cut;
        int          pos;
        for (int i = 0; i < 64; i++) fbuf[i] = 8'($urandom);
        for (int i = 0; i < 4; i++) fbuf[i] = hdr_word[8*i +: 8];
        if (len_ofs < 3) begin
            // length field sits inside the header itself
            flen = int'({fbuf[len_ofs + 1], fbuf[len_ofs]});
            if (flen > 64 || flen < 6) flen = 6;
        end else begin
            lo_min = cmd_ofs + 3;
            if (len_ofs + 4 > lo_min) lo_min = len_ofs + 4;
            if (lo_min < 6) lo_min = 6;
            flen = longest ? 64 : $urandom_range(lo_min, lo_min + 10);
            fbuf[len_ofs]     = 8'(flen);
            fbuf[len_ofs + 1] = 8'(flen >> 8);
        end
        crc = crc16_modbus(fbuf, flen - 2);
        fbuf[flen-2] = crc[7:0];
        fbuf[flen-1] = crc[15:8];
        if (flavor == 1) begin
            pos = $urandom_range(0, flen - 1);
            fbuf[pos][$urandom_range(0, 7)] ^= 1'b1;
        end
        cut = (flavor == 2) ? $urandom_range(1, flen - 1) : flen;
        for (int i = 0; i < cut; i++) send_beat(rbfd_pkg::CMD_RECEIVE, fbuf[i]);
        send_beat(rbfd_pkg::CMD_PARSE, 8'($urandom));
    endtask

    // Directed rows under the reset registers (header 0, length at 5,
    // command at 9). Rows marked no_frame must give a single empty beat.
    typedef struct packed {
        logic       cmd;
        logic [7:0] rx;
        logic       no_frame;
    } t_dir_row;

    localparam int DIR_ROWS = 13;
    t_dir_row dir_tab [0:DIR_ROWS-1] = '{
        '{rbfd_pkg::CMD_PARSE,   8'h00, 1'b1},   // empty ring
        '{rbfd_pkg::CMD_RECEIVE, 8'hFF, 1'b0},
        '{rbfd_pkg::CMD_RECEIVE, 8'h00, 1'b0},
        '{rbfd_pkg::CMD_RECEIVE, 8'h80, 1'b0},
        '{rbfd_pkg::CMD_PARSE,   8'hFF, 1'b1},   // under four unread bytes
        '{rbfd_pkg::CMD_RECEIVE, 8'h01, 1'b0},
        '{rbfd_pkg::CMD_PARSE,   8'h00, 1'b1},   // no header, keep last three
        '{rbfd_pkg::CMD_RECEIVE, 8'h00, 1'b0},
        '{rbfd_pkg::CMD_RECEIVE, 8'h00, 1'b0},
        '{rbfd_pkg::CMD_RECEIVE, 8'h00, 1'b0},
        '{rbfd_pkg::CMD_RECEIVE, 8'h00, 1'b0},
        '{rbfd_pkg::CMD_PARSE,   8'h00, 1'b1},   // header found, too short for length
        '{rbfd_pkg::CMD_RECEIVE, 8'h7F, 1'b0}
    };

    // ------------------------------------------------------------------
    // Output side: random back-pressure, check each beat in order.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int calm_timer = 0;

    always @(negedge i_clk) begin
        calm_timer <= calm_timer + 1;
        if (calm_timer % 300 == 299) calm <= ($urandom_range(0, 2) == 0);
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        rbfd_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (frame_beats_q.size() == 0) begin
                report_mismatch("unexpected beat", int'(out_if.data), 0);
            end else begin
                want = frame_beats_q.pop_front();
                if (out_if.data.kind != want.kind)
                    report_mismatch("kind", out_if.data.kind, want.kind);
                if (out_if.data.frame_byte != want.frame_byte)
                    report_mismatch("frame_byte", out_if.data.frame_byte, want.frame_byte);
                if (out_if.data.frame_command != want.frame_command)
                    report_mismatch("frame_command", out_if.data.frame_command,
                                    want.frame_command);
                if (out_if.data.frame_length != want.frame_length)
                    report_mismatch("frame_length", out_if.data.frame_length,
                                    want.frame_length);
                if (out_if.data.last != want.last)
                    report_mismatch("last", out_if.data.last, want.last);
            end
        end
    end

    // Watchdog: cycles in a row with no beat moving on either side.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ring_buffer_frame_deframer_crc16 regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int sel;
        int n;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        shadow_rd = '0;
        shadow_wr = '0;
        hdr_word  = 32'h0;
        len_ofs   = 5;
        cmd_ofs   = 9;
        for (int i = 0; i < rbfd_pkg::RING_DEPTH; i++) shadow_ring[i] = 8'h00;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: pointer corner cases, then a clean and a broken frame
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(dir_tab[i].cmd, dir_tab[i].rx);
            if (dir_tab[i].no_frame &&
                (frame_beats_q.size() == 0 ||
                 frame_beats_q[$] != rbfd_pkg::t_result'(1)))
                report_mismatch("directed empty beat", 0, 1);
        end
        send_frame(0, 1'b0);
        send_frame(1, 1'b0);

        // random phases, each under its own register setting
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(rbfd_pkg::REG_HEADER,  32'hFFFF_FFFF);
                    write_reg(rbfd_pkg::REG_LEN_OFS, 32'd15);
                    write_reg(rbfd_pkg::REG_CMD_OFS, 32'd15);
                end
                1: begin
                    write_reg(rbfd_pkg::REG_HEADER,  $urandom);
                    write_reg(rbfd_pkg::REG_LEN_OFS, 32'd4);
                    write_reg(rbfd_pkg::REG_CMD_OFS, 32'd0);
                end
                2: begin
                    // length field overlaps the header: header encodes 16
                    write_reg(rbfd_pkg::REG_HEADER,  {16'($urandom), 16'h0010});
                    write_reg(rbfd_pkg::REG_LEN_OFS, 32'd0);
                    write_reg(rbfd_pkg::REG_CMD_OFS, 32'd3);
                end
                default: begin
                    write_reg(rbfd_pkg::REG_HEADER,  $urandom);
                    write_reg(rbfd_pkg::REG_LEN_OFS, $urandom_range(4, 15));
                    write_reg(rbfd_pkg::REG_CMD_OFS, $urandom_range(0, 15));
                end
            endcase
            while (items_sent < 60 + (ph + 1) * 55) begin
                sel = $urandom_range(0, 9);
                if (sel < 6) begin
                    send_frame(0, $urandom_range(0, 9) == 0);
                end else if (sel == 6) begin
                    send_frame(1, 1'b0);
                end else if (sel == 7) begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_beat(rbfd_pkg::CMD_RECEIVE, 8'($urandom));
                end else if (sel == 8) begin
                    send_beat(rbfd_pkg::CMD_PARSE, 8'($urandom));
                end else begin
                    send_frame(2, 1'b0);
                end
            end
        end

        while (frame_beats_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && frame_beats_q.size() == 0) begin
            $display("ring_buffer_frame_deframer_crc16 regression: pass");
        end else begin
            $display("ring_buffer_frame_deframer_crc16 regression: fail");
        end
        $finish;
    end

endmodule

FILE: ring_buffer_frame_deframer_crc16.f
design/rbfd_pkg.sv
design/rbfd_if.sv
design/rbfd_ram.sv
design/ring_buffer_frame_deframer_crc16.sv
tb/tb_ring_buffer_frame_deframer_crc16.sv
